/* rtl/pobt_pkg.sv */
// pobt_pkg: shared types and constants for the positional order book table
// holds the entry layout, mode and status codes, sequencer states and ram command
// no dependencies
package pobt_pkg;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 31;
  localparam int POS_W   = 8;

  // one stored level: price in hundredths and quantity
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_MODIFY = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_MOD_RD,
    S_MOD_WR,
    S_DEL_RD,
    S_DEL_HOLD,
    S_DL_RD,
    S_DL_WR,
    S_DP_RD,
    S_DP_EMIT,
    S_RESP
  } seq_state_t;

  // read and write strobes toward the level memory
  typedef struct packed {
    logic wr;
    logic rd;
  } ram_cmd_t;

endpackage

/* rtl/pobt_ram.sv */
// pobt_ram: level memory, one write port and one read port with registered read data
// depends on pobt_pkg for level_t and ram_cmd_t
module pobt_ram
  import pobt_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  ram_cmd_t      cmd,
  input  logic [AW-1:0] wr_addr,
  input  level_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output level_t        rd_data
);

  level_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/positional_order_book_table.sv */
// insert: read and write per entry moved down, write of the new entry, reply word;
// delete: read, hold, read and write per entry moved up, reply; modify: read, write,
// reply; dump: read and emit per entry; one word at a time; all moves go through the
// level memory, one read or write per cycle, so the shifted entry count sets the time
// of insert and delete; reset: synchronous, clears the level count, the sequencer and
// out_valid; memory is not cleared, no clearing pass, the block is ready once reset drops
module positional_order_book_table
  import pobt_pkg::*;
#(
  parameter int MAX_LEVELS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [POS_W-1:0]   level_pos,
  input  logic [PRICE_W-1:0] price_in,
  input  logic [QTY_W-1:0]   qty_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   level_out,
  output logic [PRICE_W-1:0] price_out,
  output logic [QTY_W-1:0]   qty_out,
  output logic [1:0]         result_status,
  output logic               last_of_run
);

  localparam int IW = $clog2(MAX_LEVELS);
  localparam int CW = $clog2(MAX_LEVELS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LEVELS);

  seq_state_t state, state_next;

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      idx;
  logic [IW-1:0]      tgt;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]   qty_r;
  logic [POS_W-1:0]   res_level;
  status_e            res_status;

  // memory interface
  ram_cmd_t      ram_cmd;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  level_t        ram_wdata;
  level_t        ram_rdata;
  level_t        merged;

  // request decode
  logic               in_accept;
  mode_e              in_mode;
  logic [POS_W-1:0]   pos1;
  logic [POS_W:0]     pos_w;
  logic [POS_W:0]     cnt_w;
  logic [POS_W:0]     ins_p;
  logic               full;
  logic               absent;
  logic               append;
  logic [IW-1:0]      ins_tgt;
  logic [IW-1:0]      exist_tgt;

  // output stage
  logic               out_free;
  logic               out_load;
  logic               dump_last;
  logic [POS_W-1:0]   lvl_o_next;
  logic [PRICE_W-1:0] price_o_next;
  logic [QTY_W-1:0]   qty_o_next;
  status_e            status_o_next;
  logic               last_o_next;

  pobt_ram #(
    .DEPTH(MAX_LEVELS),
    .AW   (IW)
  ) u_ram (
    .clk    (clk),
    .cmd    (ram_cmd),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // request decode against the current count
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_mode   = mode_e'(mode);
  assign pos1      = (level_pos == '0) ? POS_W'(1) : level_pos;
  assign pos_w     = {1'b0, pos1};
  assign cnt_w     = (POS_W+1)'(cnt);
  assign full      = (cnt == CNT_MAX);
  assign absent    = (pos_w > cnt_w);
  assign ins_p     = (pos_w > cnt_w + 1'b1) ? (cnt_w + 1'b1) : pos_w;
  assign append    = (ins_p == cnt_w + 1'b1);
  assign ins_tgt   = IW'(ins_p - 1'b1);
  assign exist_tgt = IW'(pos_w - 1'b1);

  // modify merge: zero field keeps the stored value
  assign merged.price = (price_r != '0) ? price_r : ram_rdata.price;
  assign merged.qty   = (qty_r != '0) ? qty_r : ram_rdata.qty;

  assign out_free  = !out_valid || !out_stall;
  assign dump_last = (idx + 1'b1 == cnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_mode)
            MODE_INSERT: begin
              if (full)        state_next = S_RESP;
              else if (append) state_next = S_INS_WR;
              else             state_next = S_SH_RD;
            end
            MODE_MODIFY: state_next = absent ? S_RESP : S_MOD_RD;
            MODE_DELETE: state_next = absent ? S_RESP : S_DEL_RD;
            MODE_DUMP:   state_next = (cnt == '0) ? S_RESP : S_DP_RD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_SH_RD:  state_next = S_SH_WR;
      S_SH_WR:  state_next = (idx[IW-1:0] == tgt) ? S_INS_WR : S_SH_RD;
      S_INS_WR: state_next = S_RESP;
      S_MOD_RD: state_next = S_MOD_WR;
      S_MOD_WR: state_next = S_RESP;
      S_DEL_RD: state_next = S_DEL_HOLD;
      S_DEL_HOLD: begin
        state_next = ((CW'(tgt) + 1'b1) < cnt) ? S_DL_RD : S_RESP;
      end
      S_DL_RD:  state_next = S_DL_WR;
      S_DL_WR:  state_next = (idx < cnt) ? S_DL_RD : S_RESP;
      S_DP_RD:  state_next = S_DP_EMIT;
      S_DP_EMIT: begin
        if (out_free) state_next = dump_last ? S_IDLE : S_DP_RD;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory strobes and output word
  always_comb begin
    ram_cmd       = '0;
    ram_raddr     = idx[IW-1:0];
    ram_waddr     = tgt;
    ram_wdata     = ram_rdata;
    out_load      = 1'b0;
    lvl_o_next    = res_level;
    price_o_next  = price_r;
    qty_o_next    = qty_r;
    status_o_next = res_status;
    last_o_next   = 1'b1;
    unique case (state) inside
      S_SH_RD, S_DL_RD, S_DP_RD: begin
        ram_cmd.rd = 1'b1;
      end
      S_MOD_RD, S_DEL_RD: begin
        ram_cmd.rd = 1'b1;
        ram_raddr  = tgt;
      end
      S_SH_WR: begin
        ram_cmd.wr = 1'b1;
        ram_waddr  = idx[IW-1:0] + 1'b1;
      end
      S_DL_WR: begin
        ram_cmd.wr = 1'b1;
        ram_waddr  = idx[IW-1:0] - 1'b1;
      end
      S_INS_WR: begin
        ram_cmd.wr      = 1'b1;
        ram_wdata.price = price_r;
        ram_wdata.qty   = qty_r;
      end
      S_MOD_WR: begin
        ram_cmd.wr = 1'b1;
        ram_wdata  = merged;
      end
      S_DP_EMIT: begin
        out_load      = out_free;
        lvl_o_next    = POS_W'(idx + 1'b1);
        price_o_next  = ram_rdata.price;
        qty_o_next    = ram_rdata.qty;
        status_o_next = ST_OK;
        last_o_next   = dump_last;
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: begin
        ram_cmd = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            idx <= (in_mode == MODE_INSERT) ? (cnt - 1'b1) : '0;
          end
        end
        S_SH_WR:    idx <= idx - 1'b1;
        S_INS_WR:   cnt <= cnt + 1'b1;
        S_DEL_HOLD: begin
          idx <= CW'(tgt) + 1'b1;
          cnt <= cnt - 1'b1;
        end
        S_DL_WR:    idx <= idx + 1'b1;
        S_DP_EMIT: begin
          if (out_free) idx <= idx + 1'b1;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // request capture and held entry
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_accept) begin
      case (in_mode) inside
        MODE_INSERT: begin
          tgt <= ins_tgt;
          if (full) begin
            price_r    <= '0;
            qty_r      <= '0;
            res_level  <= '0;
            res_status <= ST_FULL;
          end else begin
            price_r    <= price_in;
            qty_r      <= qty_in;
            res_level  <= POS_W'(ins_p);
            res_status <= ST_OK;
          end
        end
        MODE_MODIFY, MODE_DELETE: begin
          tgt <= exist_tgt;
          if (absent) begin
            price_r    <= '0;
            qty_r      <= '0;
            res_level  <= '0;
            res_status <= ST_ABSENT;
          end else begin
            price_r    <= price_in;
            qty_r      <= qty_in;
            res_level  <= pos1;
            res_status <= ST_OK;
          end
        end
        default: begin
          tgt        <= exist_tgt;
          price_r    <= '0;
          qty_r      <= '0;
          res_level  <= '0;
          res_status <= ST_EMPTY;
        end
      endcase
    end else if (state == S_MOD_WR) begin
      price_r <= merged.price;
      qty_r   <= merged.qty;
    end else if (state == S_DEL_HOLD) begin
      price_r <= ram_rdata.price;
      qty_r   <= ram_rdata.qty;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      level_out     <= lvl_o_next;
      price_out     <= price_o_next;
      qty_out       <= qty_o_next;
      result_status <= status_o_next;
      last_of_run   <= last_o_next;
    end
  end

  // count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_MAX)
    else $error("level count above table depth");

  // memory is never read and written in the same cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (rst) !(ram_cmd.wr && ram_cmd.rd))
    else $error("level memory read and write collide");

  // an insert into a full table leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
      in_accept && in_mode == MODE_INSERT && full |=> cnt == CNT_MAX)
    else $error("dropped insert changed the count");

  // the last dump word returns the sequencer to idle
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
      state == S_DP_EMIT && out_load && dump_last |=> state == S_IDLE)
    else $error("dump did not finish after last word");

  // no memory write while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
      state == S_IDLE |-> !ram_cmd.wr)
    else $error("memory written while idle");

endmodule

/* dv/positional_order_book_table_test.sv */
// self-checking testbench for the positional order book table
// drives insert, modify, delete and dump words, checks replies against a book model or typed row
// depends on rtl/pobt_pkg.sv and rtl/positional_order_book_table.sv
`timescale 1ns / 100ps

module positional_order_book_table_test;
  import pobt_pkg::*;

  localparam int MAX_LEVELS   = 32;
  localparam int RAND_WORDS   = 340;
  localparam int PHASE_LEN    = 60;
  localparam int DRAIN_CYCLES = 100;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int REPORT_MAX   = 10;

  // one reply word as the block reports it
  typedef struct {
    logic [POS_W-1:0]   at;
    logic [PRICE_W-1:0] px;
    logic [QTY_W-1:0]   qt;
    status_e            status;
    logic               last;
  } book_word_t;

  // one directed stimulus row, with an optional hand-written reply
  typedef struct {
    mode_e              op;
    logic [POS_W-1:0]   at;
    logic [PRICE_W-1:0] px;
    logic [QTY_W-1:0]   qt;
    bit                 typed;
    book_word_t         want;
  } stim_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_INSERT;
  logic [POS_W-1:0]   level_pos = '0;
  logic [PRICE_W-1:0] price_in = '0;
  logic [QTY_W-1:0]   qty_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [POS_W-1:0]   level_out;
  logic [PRICE_W-1:0] price_out;
  logic [QTY_W-1:0]   qty_out;
  logic [1:0]         result_status;
  logic               last_of_run;

  // local copy of the book
  level_t     book_levels [MAX_LEVELS];
  int         book_depth = 0;
  book_word_t book_replies [$];
  book_word_t pending_words [$];
  stim_row_t  stim_rows [$];

  int  fail_count    = 0;
  int  checked_words = 0;
  int  sent_words    = 0;
  int  full_hits     = 0;
  int  absent_hits   = 0;
  int  empty_hits    = 0;
  int  dump_runs     = 0;
  int  cycle_count   = 0;
  int  burst_left    = 0;
  logic [8:0] stall_tick = '0;

  positional_order_book_table #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .level_pos    (level_pos),
    .price_in     (price_in),
    .qty_in       (qty_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level_out    (level_out),
    .price_out    (price_out),
    .qty_out      (qty_out),
    .result_status(result_status),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic book_word_t make_word(input int at, input logic [PRICE_W-1:0] px,
                                           input logic [QTY_W-1:0] qt, input status_e st,
                                           input logic last);
    book_word_t w;
    w.at = at[POS_W-1:0];
    w.px = px;
    w.qt = qt;
    w.status = st;
    w.last = last;
    return w;
  endfunction

  // queue helpers: append at the tail
  function automatic void reply_add(input book_word_t w);
    book_replies = {book_replies, w};
  endfunction

  function automatic void pend_add(input book_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void row_add(input stim_row_t r);
    stim_rows = {stim_rows, r};
  endfunction

  // book model: applies one word and queues the replies it causes
  function automatic void book_apply(input mode_e op, input logic [POS_W-1:0] at,
                                     input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] qt);
    int     slot;
    level_t hit;
    slot = (at == 0) ? 1 : int'(at);
    case (op) inside
      MODE_INSERT: begin
        if (book_depth >= MAX_LEVELS) begin
          full_hits++;
          reply_add(make_word(0, '0, '0, ST_FULL, 1'b1));
        end else begin
          // land at the slot, existing entries move down
          if (slot > book_depth + 1) slot = book_depth + 1;
          for (int i = book_depth; i >= slot; i--) book_levels[i] = book_levels[i-1];
          book_levels[slot-1].price = px;
          book_levels[slot-1].qty = qt;
          book_depth++;
          reply_add(make_word(slot, px, qt, ST_OK, 1'b1));
        end
      end
      MODE_MODIFY, MODE_DELETE: begin
        if (slot > book_depth) begin
          absent_hits++;
          reply_add(make_word(0, '0, '0, ST_ABSENT, 1'b1));
        end else if (op == MODE_MODIFY) begin
          // zero fields keep the stored value
          if (px != 0) book_levels[slot-1].price = px;
          if (qt != 0) book_levels[slot-1].qty = qt;
          hit = book_levels[slot-1];
          reply_add(make_word(slot, hit.price, hit.qty, ST_OK, 1'b1));
        end else begin
          hit = book_levels[slot-1];
          for (int i = slot; i < book_depth; i++) book_levels[i-1] = book_levels[i];
          book_depth--;
          reply_add(make_word(slot, hit.price, hit.qty, ST_OK, 1'b1));
        end
      end
      default: begin
        dump_runs++;
        if (book_depth == 0) begin
          empty_hits++;
          reply_add(make_word(0, '0, '0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < book_depth; i++)
            reply_add(make_word(i + 1, book_levels[i].price, book_levels[i].qty,
                                ST_OK, (i + 1 == book_depth)));
        end
      end
    endcase
  endfunction

  function automatic void add_row(input mode_e op, input logic [POS_W-1:0] at,
                                  input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] qt);
    stim_row_t r;
    r.op = op;
    r.at = at;
    r.px = px;
    r.qt = qt;
    r.typed = 1'b0;
    r.want = make_word(0, '0, '0, ST_OK, 1'b1);
    row_add(r);
  endfunction

  // row whose single reply is written out by hand
  function automatic void add_typed(input mode_e op, input logic [POS_W-1:0] at,
                                    input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] qt,
                                    input book_word_t want);
    add_row(op, at, px, qt);
    stim_rows[$].typed = 1'b1;
    stim_rows[$].want = want;
  endfunction

  // send one word in bursts with random gaps, then wait for acceptance
  task automatic send_word(input mode_e op, input logic [POS_W-1:0] at,
                           input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] qt);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 70)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    mode <= op;
    level_pos <= at;
    price_in <= px;
    qty_in <= qt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent_words++;
  endtask

  // receiver stall pattern, cycling through calm, light, periodic and heavy stretches
  always @(posedge clk) begin
    stall_tick <= stall_tick + 9'd1;
    case (stall_tick[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= (stall_tick[2:0] < 3'd3);
      default: out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  // compare each accepted reply with the oldest pending word
  always @(posedge clk) begin : check_out
    book_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected word: pos %0d price %h qty %h status %0d last %0b",
                   level_out, price_out, qty_out, result_status, last_of_run);
      end else begin
        want = pending_words.pop_front();
        checked_words++;
        if (level_out !== want.at || price_out !== want.px || qty_out !== want.qt ||
            result_status !== want.status || last_of_run !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("mismatch on word %0d", checked_words);
            $display("  expected pos %0d price %h qty %h status %0d last %0b",
                     want.at, want.px, want.qt, want.status, want.last);
            $display("  actual   pos %0d price %h qty %h status %0d last %0b",
                     level_out, price_out, qty_out, result_status, last_of_run);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("run limit of %0d cycles reached, %0d words pending", LIMIT_CYCLES,
               pending_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    phase_e             phase;
    mode_e              op;
    logic [POS_W-1:0]   at;
    logic [PRICE_W-1:0] px;
    logic [QTY_W-1:0]   qt;
    int                 pick;

    // directed table
    add_typed(MODE_DUMP,   8'd0,   '0, '0, make_word(0, '0, '0, ST_EMPTY, 1'b1));
    add_typed(MODE_DELETE, 8'd1,   '0, '0, make_word(0, '0, '0, ST_ABSENT, 1'b1));
    add_typed(MODE_MODIFY, 8'd0,   32'd5, 31'd5, make_word(0, '0, '0, ST_ABSENT, 1'b1));
    add_typed(MODE_INSERT, 8'd0,   32'hFFFF_FFFF, 31'h7FFF_FFFF,
              make_word(1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, ST_OK, 1'b1));
    add_typed(MODE_INSERT, 8'd255, '0, '0, make_word(2, '0, '0, ST_OK, 1'b1));
    add_row(MODE_INSERT, 8'd1,   32'd100, 31'd5);
    add_row(MODE_INSERT, 8'd2,   32'd200, 31'd7);
    add_row(MODE_DUMP,   8'd0,   '0, '0);
    add_row(MODE_MODIFY, 8'd2,   '0, 31'd9);
    add_row(MODE_MODIFY, 8'd3,   32'd333, '0);
    add_row(MODE_MODIFY, 8'd4,   32'hFFFF_FFFF, 31'h7FFF_FFFF);
    add_typed(MODE_MODIFY, 8'd5,   32'd1, 31'd1, make_word(0, '0, '0, ST_ABSENT, 1'b1));
    add_typed(MODE_DELETE, 8'd255, '0, '0, make_word(0, '0, '0, ST_ABSENT, 1'b1));
    add_row(MODE_DELETE, 8'd0,   32'hFFFF_FFFF, 31'h7FFF_FFFF);
    add_row(MODE_DELETE, 8'd3,   '0, '0);
    add_row(MODE_DUMP,   8'd255, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    add_row(MODE_MODIFY, 8'd1,   '0, '0);
    add_row(MODE_DELETE, 8'd1,   '0, '0);
    add_row(MODE_DELETE, 8'd1,   '0, '0);
    add_typed(MODE_DUMP,   8'd0,   '0, '0, make_word(0, '0, '0, ST_EMPTY, 1'b1));
    add_row(MODE_INSERT, 8'd1,   32'd1, 31'd1);
    add_row(MODE_DUMP,   8'd1,   '0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (stim_rows[k]) begin
      send_word(stim_rows[k].op, stim_rows[k].at, stim_rows[k].px, stim_rows[k].qt);
      book_apply(stim_rows[k].op, stim_rows[k].at, stim_rows[k].px, stim_rows[k].qt);
      if (stim_rows[k].typed) pend_add(stim_rows[k].want);
      else foreach (book_replies[j]) pend_add(book_replies[j]);
      book_replies.delete();
    end

    // random words in fill, drain and mixed phases
    for (int n = 0; n < RAND_WORDS; n++) begin
      case ((n / PHASE_LEN) % 6) inside
        0, 3:    phase = PH_FILL;
        2, 4:    phase = PH_DRAIN;
        default: phase = PH_MIXED;
      endcase
      pick = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  op = (pick < 82) ? MODE_INSERT : (pick < 90) ? MODE_MODIFY :
                       (pick < 94) ? MODE_DELETE : MODE_DUMP;
        PH_DRAIN: op = (pick < 70) ? MODE_DELETE : (pick < 82) ? MODE_MODIFY :
                       (pick < 88) ? MODE_INSERT : MODE_DUMP;
        default:  op = (pick < 30) ? MODE_INSERT : (pick < 55) ? MODE_MODIFY :
                       (pick < 82) ? MODE_DELETE : MODE_DUMP;
      endcase
      // positions mostly near the occupied range, some zero and some anywhere
      pick = $urandom_range(0, 99);
      if (pick < 10) at = '0;
      else if (pick < 30) at = POS_W'($urandom_range(0, 255));
      else at = POS_W'($urandom_range(1, book_depth + 2));
      pick = $urandom_range(0, 99);
      px = (pick < 10) ? '0 : (pick < 18) ? 32'hFFFF_FFFF : $urandom;
      pick = $urandom_range(0, 99);
      qt = (pick < 10) ? '0 : (pick < 16) ? 31'h7FFF_FFFF : QTY_W'($urandom);
      send_word(op, at, px, qt);
      book_apply(op, at, px, qt);
      foreach (book_replies[j]) pend_add(book_replies[j]);
      book_replies.delete();
    end
    in_valid <= 1'b0;

    // let every reply arrive, then watch for strays
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d replies checked, %0d dumps", sent_words, checked_words,
             dump_runs);
    $display("drops on full book %0d, absent positions %0d, empty dumps %0d",
             full_hits, absent_hits, empty_hits);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
